// ===== rtl/pm_pkg.sv =====
package pm_pkg;

   localparam int DATA_W        = 32;
   localparam int TERM_W        = 6;
   localparam int DEF_MAX_TERMS = 32;
   localparam int DEF_FRAC_BITS = 16;

   typedef struct packed {
      logic clear;
      logic advance;
   } cell_ctl_type;

endpackage

// ===== rtl/pm_cell.sv =====
module pm_cell #(
   parameter int SUM_W = 2 * pm_pkg::DATA_W + 5
) (
   input  logic                                clock,
   input  pm_pkg::cell_ctl_type                ctl,
   input  logic                                a_load,
   input  logic                                b_load,
   input  logic                                a_en,
   input  logic signed [pm_pkg::DATA_W-1:0]    coef,
   input  logic signed [pm_pkg::DATA_W-1:0]    x,
   input  logic signed [pm_pkg::DATA_W-1:0]    b_up,
   input  logic signed [SUM_W-1:0]             sum_up,
   output logic signed [pm_pkg::DATA_W-1:0]    b_out,
   output logic signed [SUM_W-1:0]             sum_out
);
   import pm_pkg::*;

   logic signed [DATA_W-1:0]   a_ff;
   logic signed [DATA_W-1:0]   b_ff;
   logic signed [2*DATA_W-1:0] prod_ff;
   logic signed [2*DATA_W-1:0] prod_in;
   logic signed [SUM_W-1:0]    sum_ff;
   logic signed [SUM_W-1:0]    sum_in;

   always_comb begin
      prod_in = '0;
      if (a_en) begin
         prod_in = a_ff * x;
      end
      sum_in  = sum_up + SUM_W'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_ff <= coef;
      end
      if (b_load) begin
         b_ff <= coef;
      end else if (ctl.advance) begin
         b_ff <= b_up;
      end
      if (ctl.clear) begin
         prod_ff <= '0;
         sum_ff  <= '0;
      end else if (ctl.advance) begin
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
      end
   end

   assign b_out   = b_ff;
   assign sum_out = sum_ff;

endmodule

// ===== rtl/polynomial_multiply.sv =====
// Linear convolution of two polynomials over a chain of MAX_TERMS cells, each holding one
// coefficient of each operand, with its own 32x32 multiplier and a slice of the accumulation
// chain. Coefficients are taken one a cycle, lowest power first, while the block is idle. The
// request that completes the later of the two operands starts a burst of first_count+second_count-1
// product coefficients: the second operand shifts down the chain one place a cycle while the
// result channel is free, and once the product and sum registers have filled one result leaves
// per cycle unless that channel stalls. No request is taken during the burst; any stall on
// the result channel stalls the whole chain.
module polynomial_multiply #(
   parameter int MAX_TERMS = pm_pkg::DEF_MAX_TERMS,
   parameter int FRAC_BITS = pm_pkg::DEF_FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_command,
   input  logic signed [pm_pkg::DATA_W-1:0]  req_coefficient,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [pm_pkg::DATA_W-1:0]  rsp_product_coefficient,
   output logic [pm_pkg::TERM_W-1:0]         rsp_term_index,
   output logic                              rsp_saturated,
   output logic                              rsp_final_term
);
   import pm_pkg::*;

   localparam int CNT_W  = $clog2(MAX_TERMS + 1);
   localparam int STEP_W = $clog2(2 * MAX_TERMS + 1);
   localparam int SUM_W  = 2 * DATA_W + $clog2(MAX_TERMS);

   typedef enum logic {IDLE, RUN} state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      first_count_ff, first_count_in;
   logic [CNT_W-1:0]      second_count_ff, second_count_in;
   logic                  first_done_ff, first_done_in;
   logic                  second_done_ff, second_done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_coef_ff, rsp_coef_in;
   logic [TERM_W-1:0]     rsp_term_ff, rsp_term_in;
   logic                  rsp_sat_ff, rsp_sat_in;
   logic                  rsp_final_ff, rsp_final_in;

   logic                  accept;
   logic                  load_a;
   logic                  load_b;
   logic                  first_done_next;
   logic                  second_done_next;
   logic                  advance;
   logic                  emit;
   logic                  last_step;
   logic [STEP_W-1:0]     total;
   cell_ctl_type          ctl;
   logic signed [DATA_W-1:0] x;
   logic signed [DATA_W-1:0] b_chain [MAX_TERMS+1];
   logic signed [SUM_W-1:0]  sum_chain [MAX_TERMS+1];
   logic signed [SUM_W-1:0]  shifted;
   logic                  fits;
   logic signed [DATA_W-1:0] clip;

   assign req_ready = (state_ff == IDLE);
   assign accept    = req_valid && req_ready;
   assign load_a    = accept && !req_command && !first_done_ff
                      && (first_count_ff < CNT_W'(MAX_TERMS));
   assign load_b    = accept && req_command && !second_done_ff
                      && (second_count_ff < CNT_W'(MAX_TERMS));
   assign first_done_next  = first_done_ff || (accept && !req_command && req_last);
   assign second_done_next = second_done_ff || (accept && req_command && req_last);

   assign total     = STEP_W'(first_count_ff) + STEP_W'(second_count_ff) - STEP_W'(1);
   assign advance   = (state_ff == RUN) && (!rsp_valid_ff || rsp_ready);
   assign emit      = advance && (step_ff >= STEP_W'(2));
   assign last_step = (step_ff == total + STEP_W'(1));

   assign ctl.clear   = (state_ff == IDLE);
   assign ctl.advance = advance;

   assign b_chain[MAX_TERMS]   = '0;
   assign sum_chain[MAX_TERMS] = '0;
   assign x = (step_ff < STEP_W'(second_count_ff)) ? b_chain[0] : '0;

   for (genvar i = 0; i < MAX_TERMS; i++) begin : g_cell
      pm_cell #(
         .SUM_W (SUM_W)
      ) u_cell (
         .clock   (clock),
         .ctl     (ctl),
         .a_load  (load_a && (first_count_ff == CNT_W'(i))),
         .b_load  (load_b && (second_count_ff == CNT_W'(i))),
         .a_en    (CNT_W'(i) < first_count_ff),
         .coef    (req_coefficient),
         .x       (x),
         .b_up    (b_chain[i+1]),
         .sum_up  (sum_chain[i+1]),
         .b_out   (b_chain[i]),
         .sum_out (sum_chain[i])
      );
   end

   always_comb begin
      shifted = sum_chain[0] >>> FRAC_BITS;
      fits    = (&shifted[SUM_W-1:DATA_W-1]) || !(|shifted[SUM_W-1:DATA_W-1]);
      clip    = shifted[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
   end

   always_comb begin
      state_in        = state_ff;
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      first_done_in   = first_done_ff;
      second_done_in  = second_done_ff;
      step_in         = step_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_coef_in     = rsp_coef_ff;
      rsp_term_in     = rsp_term_ff;
      rsp_sat_in      = rsp_sat_ff;
      rsp_final_in    = rsp_final_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         IDLE: begin
            if (accept) begin
               first_count_in  = first_count_ff + CNT_W'(load_a);
               second_count_in = second_count_ff + CNT_W'(load_b);
               first_done_in   = first_done_next;
               second_done_in  = second_done_next;
               if (first_done_next && second_done_next) begin
                  state_in = RUN;
                  step_in  = '0;
               end
            end
         end
         RUN: begin
            if (advance) begin
               step_in = step_ff + STEP_W'(1);
            end
            if (emit) begin
               rsp_valid_in = 1'b1;
               rsp_coef_in  = fits ? shifted[DATA_W-1:0] : clip;
               rsp_sat_in   = !fits;
               rsp_term_in  = TERM_W'(step_ff - STEP_W'(2));
               rsp_final_in = last_step;
               if (last_step) begin
                  state_in        = IDLE;
                  first_count_in  = '0;
                  second_count_in = '0;
                  first_done_in   = 1'b0;
                  second_done_in  = 1'b0;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= IDLE;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         first_done_ff   <= 1'b0;
         second_done_ff  <= 1'b0;
         step_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         first_done_ff   <= first_done_in;
         second_done_ff  <= second_done_in;
         step_ff         <= step_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_coef_ff  <= rsp_coef_in;
      rsp_term_ff  <= rsp_term_in;
      rsp_sat_ff   <= rsp_sat_in;
      rsp_final_ff <= rsp_final_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_product_coefficient = rsp_coef_ff;
   assign rsp_term_index          = rsp_term_ff;
   assign rsp_saturated           = rsp_sat_ff;
   assign rsp_final_term          = rsp_final_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (first_count_ff <= CNT_W'(MAX_TERMS)) && (second_count_ff <= CNT_W'(MAX_TERMS)))
      else $error("operand count beyond capacity");

   a_run_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == RUN) |-> (first_count_ff != '0) && (second_count_ff != '0)
                            && first_done_ff && second_done_ff)
      else $error("burst running without both operands complete");

   a_final_ends: assert property (@(posedge clock) disable iff (reset)
      (emit && last_step) |=> (state_ff == IDLE) && rsp_valid_ff && rsp_final_ff
                              && (first_count_ff == '0) && (second_count_ff == '0))
      else $error("final result did not close the burst");

   a_term_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ready && !rsp_final_ff)
      |=> rsp_valid_ff && (rsp_term_ff == TERM_W'($past(rsp_term_ff) + TERM_W'(1))))
      else $error("product terms out of order");

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pm_pkg::*;

   localparam int MAX_TERMS    = DEF_MAX_TERMS;
   localparam int FRAC_BITS    = DEF_FRAC_BITS;
   localparam int RANDOM_ITEMS = 420;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 200000;

   typedef enum logic {
      FIRST_OPERAND  = 1'b0,
      SECOND_OPERAND = 1'b1
   } operand_type;

   typedef struct packed {
      operand_type       cmd;
      logic [DATA_W-1:0] coef;
      logic              lst;
      logic              typed;
      logic [DATA_W-1:0] want;
      logic              want_sat;
   } stim_row_type;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      logic [TERM_W-1:0]        term;
      logic                     sat;
      logic                     fin;
   } product_type;

   localparam stim_row_type DIRECTED [0:24] = '{
      '{FIRST_OPERAND,  32'h0001_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{SECOND_OPERAND, 32'h0001_0000, 1'b1, 1'b1, 32'h0001_0000, 1'b0},
      '{FIRST_OPERAND,  32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{SECOND_OPERAND, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b1},
      '{SECOND_OPERAND, 32'h8000_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{FIRST_OPERAND,  32'h8000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b1},
      '{FIRST_OPERAND,  32'h8000_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{SECOND_OPERAND, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h8000_0000, 1'b1},
      '{FIRST_OPERAND,  32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{SECOND_OPERAND, 32'h0000_0001, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0},
      '{SECOND_OPERAND, 32'h0003_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{SECOND_OPERAND, 32'h1234_5678, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{FIRST_OPERAND,  32'h0002_0000, 1'b1, 1'b1, 32'h0006_0000, 1'b0},
      '{FIRST_OPERAND,  32'h0001_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{SECOND_OPERAND, 32'hFFFE_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{FIRST_OPERAND,  32'h8000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{SECOND_OPERAND, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
      '{FIRST_OPERAND,  32'h0000_8000, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{SECOND_OPERAND, 32'h0003_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{FIRST_OPERAND,  32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{SECOND_OPERAND, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
      '{FIRST_OPERAND,  32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{SECOND_OPERAND, 32'h0001_0000, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b0},
      '{FIRST_OPERAND,  32'h8000_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b0},
      '{SECOND_OPERAND, 32'h0001_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b0}
   };

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic                     req_command;
   logic signed [DATA_W-1:0] req_coefficient;
   logic                     req_last;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic signed [DATA_W-1:0] rsp_product_coefficient;
   logic [TERM_W-1:0]        rsp_term_index;
   logic                     rsp_saturated;
   logic                     rsp_final_term;

   logic                     row_typed = 1'b0;
   logic [DATA_W-1:0]        row_value = '0;
   logic                     row_sat = 1'b0;
   bit                       quiet = 1'b0;
   bit                       hold_trigger = 1'b0;

   logic signed [DATA_W-1:0] first_store [MAX_TERMS];
   logic signed [DATA_W-1:0] second_store [MAX_TERMS];
   int                       first_count = 0;
   int                       second_count = 0;
   bit                       first_done = 1'b0;
   bit                       second_done = 1'b0;
   product_type              product_q [$];

   int failures = 0;
   int requests_seen = 0;
   int ignored_reqs = 0;
   int terms_checked = 0;
   int saturated_terms = 0;
   int bursts_seen = 0;
   int longest_burst = 0;
   int loaded_items = 0;
   int cycle_count;

   polynomial_multiply DUT (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_command             (req_command),
      .req_coefficient         (req_coefficient),
      .req_last                (req_last),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_product_coefficient (rsp_product_coefficient),
      .rsp_term_index          (rsp_term_index),
      .rsp_saturated           (rsp_saturated),
      .rsp_final_term          (rsp_final_term)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("run stopped after %0d cycles with %0d product terms outstanding",
               CYCLE_LIMIT, product_q.size());
      $display("CHECK FAILED");
      $finish;
   end

   // Store one coefficient request and, once both operands are complete, queue the product.
   function automatic int convolve_request(input operand_type cmd,
                                           input logic signed [DATA_W-1:0] coef,
                                           input logic lst);
      int total;
      int j;
      logic signed [127:0] acc;
      logic signed [127:0] shifted;
      product_type term;
      if (cmd == FIRST_OPERAND) begin
         if (first_done) begin
            ignored_reqs++;
            return 0;
         end
         if (first_count < MAX_TERMS) begin
            first_store[first_count] = coef;
            first_count++;
         end
         if (lst) first_done = 1'b1;
      end else begin
         if (second_done) begin
            ignored_reqs++;
            return 0;
         end
         if (second_count < MAX_TERMS) begin
            second_store[second_count] = coef;
            second_count++;
         end
         if (lst) second_done = 1'b1;
      end
      if (!(first_done && second_done)) return 0;
      total = first_count + second_count - 1;
      for (int k = 0; k < total; k++) begin
         acc = '0;
         for (int i = 0; i < first_count && i <= k; i++) begin
            j = k - i;
            if (j < second_count) acc = acc + first_store[i] * second_store[j];
         end
         shifted = acc >>> FRAC_BITS;
         if (shifted > 128'sh7FFF_FFFF) begin
            term.value = 32'h7FFF_FFFF;
            term.sat = 1'b1;
         end else if (shifted < -128'sh8000_0000) begin
            term.value = 32'h8000_0000;
            term.sat = 1'b1;
         end else begin
            term.value = shifted[DATA_W-1:0];
            term.sat = 1'b0;
         end
         term.term = TERM_W'(k);
         term.fin = (k == total - 1);
         product_q.insert(product_q.size(), term);
      end
      first_count = 0;
      second_count = 0;
      first_done = 1'b0;
      second_done = 1'b0;
      if (total > longest_burst) longest_burst = total;
      return total;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want_v,
                                input logic [31:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %h, got %h", name, want_v, got_v);
         failures++;
      end
   endtask

   always @(posedge clock) begin : monitor
      product_type want;
      int pushed;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (product_q.size() == 0) begin
               $error("unexpected product coefficient %h at term %0d",
                      rsp_product_coefficient, rsp_term_index);
               failures++;
            end else begin
               want = product_q.pop_front();
               terms_checked++;
               if (want.sat) saturated_terms++;
               if (want.fin) bursts_seen++;
               compare_field("product_coefficient", want.value, rsp_product_coefficient);
               compare_field("term_index", 32'(want.term), 32'(rsp_term_index));
               compare_field("saturated", 32'(want.sat), 32'(rsp_saturated));
               compare_field("final_term", 32'(want.fin), 32'(rsp_final_term));
            end
         end
         if (req_valid && req_ready) begin
            requests_seen++;
            pushed = convolve_request(operand_type'(req_command), req_coefficient, req_last);
            if (row_typed && pushed > 0) begin
               product_q[product_q.size() - 1].value = row_value;
               product_q[product_q.size() - 1].sat = row_sat;
            end
         end
      end
   end

   initial begin
      int hold_left;
      bit hold_taken;
      hold_left = 0;
      hold_taken = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_trigger && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= quiet || ($urandom_range(99) >= 12);
         end
      end
   end

   task automatic send_request(input operand_type cmd, input logic [DATA_W-1:0] coef,
                               input logic lst);
      while (!quiet && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_coefficient <= coef;
      req_last <= lst;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [DATA_W-1:0] random_coefficient();
      logic [31:0] r;
      logic [DATA_W-1:0] c;
      r = $urandom;
      case ($urandom_range(9))
         0, 1, 2, 3: c = {{14{r[17]}}, r[17:0]};
         4, 5: c = r;
         6: begin
            case ($urandom_range(4))
               0: c = 32'h7FFF_FFFF;
               1: c = 32'h8000_0000;
               2: c = 32'hFFFF_FFFF;
               3: c = 32'h0001_0000;
               default: c = '0;
            endcase
         end
         default: c = {{7{r[24]}}, r[24:0]};
      endcase
      return c;
   endfunction

   function automatic int product_length();
      int p;
      p = $urandom_range(99);
      if (p < 80) return $urandom_range(6, 1);
      if (p < 92) return $urandom_range(16, 7);
      if (p < 97) return MAX_TERMS;
      return $urandom_range(MAX_TERMS + 4, MAX_TERMS + 1);
   endfunction

   // Interleave both operands at random; slip in requests for an operand already complete.
   task automatic run_product(input int len_a, input int len_b);
      int ia;
      int ib;
      operand_type op;
      ia = 0;
      ib = 0;
      while (ia < len_a || ib < len_b) begin
         if (ia == len_a && $urandom_range(5) == 0) begin
            send_request(FIRST_OPERAND, random_coefficient(), $urandom_range(1) == 1);
         end
         if (ib == len_b && $urandom_range(5) == 0) begin
            send_request(SECOND_OPERAND, random_coefficient(), $urandom_range(1) == 1);
         end
         if (ia == len_a) op = SECOND_OPERAND;
         else if (ib == len_b) op = FIRST_OPERAND;
         else if ($urandom_range(1) == 1) op = SECOND_OPERAND;
         else op = FIRST_OPERAND;
         if (op == FIRST_OPERAND) begin
            ia++;
            send_request(op, random_coefficient(), ia == len_a);
         end else begin
            ib++;
            send_request(op, random_coefficient(), ib == len_b);
         end
         loaded_items++;
      end
   endtask

   initial begin
      int seq;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = 1'b0;
      req_coefficient = '0;
      req_last = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < $size(DIRECTED); r++) begin
         row_typed <= DIRECTED[r].typed;
         row_value <= DIRECTED[r].want;
         row_sat <= DIRECTED[r].want_sat;
         send_request(DIRECTED[r].cmd, DIRECTED[r].coef, DIRECTED[r].lst);
      end
      row_typed <= 1'b0;

      seq = 0;
      while (loaded_items < RANDOM_ITEMS) begin
         if (seq == 0) begin
            run_product(MAX_TERMS, MAX_TERMS);
         end else if (seq == 1) begin
            run_product(MAX_TERMS + 2, MAX_TERMS + 1);
         end else begin
            // hold the result side off while requests keep coming, so the block backs up
            if (seq == 6) hold_trigger <= 1'b1;
            quiet <= (seq >= 12 && seq < 20);
            run_product(product_length(), product_length());
         end
         seq++;
      end
      req_valid <= 1'b0;
      quiet <= 1'b0;

      while (product_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      $display("%0d coefficient requests, %0d dropped by a completed operand, %0d products",
               requests_seen, ignored_reqs, bursts_seen);
      $display("%0d product terms checked, %0d saturated, longest product %0d terms",
               terms_checked, saturated_terms, longest_burst);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/pm_pkg.sv
rtl/pm_cell.sv
rtl/polynomial_multiply.sv
verif/tb_top.sv
